// ----- rtl/core/qdv_pkg.sv -----
// shared types, register indexes and the 4x transition decode for the quadrature decoder
`default_nettype none

package qdv_pkg;

  // configuration register indexes
  localparam logic [0:0] CFG_AVERAGE_WINDOW = 1'b0;
  localparam logic [0:0] CFG_VELOCITY_SCALE = 1'b1;

  localparam logic [6:0]  WINDOW_RESET = 7'd1;
  localparam logic [31:0] SCALE_RESET  = 32'h0001_0000;

  localparam int unsigned VEL_W = 48;
  localparam int unsigned POS_W = 32;

  typedef enum logic [1:0] {
    STEP_NONE = 2'd0,
    STEP_UP   = 2'd1,
    STEP_DOWN = 2'd2
  } step_e;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_CALC = 4'b0100,
    S_OUT  = 4'b1000
  } ctl_state_e;

  typedef enum logic [2:0] {
    MD_IDLE = 3'b001,
    MD_MUL  = 3'b010,
    MD_DIV  = 3'b100
  } md_state_e;

  // 4x decode: {previous a/b, current a/b}; double jumps count nothing
  function automatic step_e qdv_step(input logic [1:0] prev_ab, input logic [1:0] cur_ab);
    logic [3:0] key;
    key = {prev_ab, cur_ab};
    if (key inside {4'b0001, 4'b0111, 4'b1000, 4'b1110}) begin
      return STEP_UP;
    end else if (key inside {4'b0010, 4'b0100, 4'b1011, 4'b1101}) begin
      return STEP_DOWN;
    end
    return STEP_NONE;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/qdv_hist_mem.sv -----
// count history ring: one write port, one registered read port
`default_nettype none

module qdv_hist_mem #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = 6,
  parameter int unsigned DATA_W = 32
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/qdv_muldiv.sv -----
// velocity unit: chunked 32x32 multiply by the scale, then 8 quotient bits per cycle by span
`default_nettype none

module qdv_muldiv #(
  parameter int unsigned COUNT_BITS = 32,
  parameter int unsigned SPAN_W     = 7
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic                  neg_i,
  input  wire logic [COUNT_BITS-1:0] mag_i,
  input  wire logic [31:0]           scale_i,
  input  wire logic [SPAN_W-1:0]     span_i,
  output logic                       done_o,
  output logic [qdv_pkg::VEL_W-1:0]  vel_o
);

  localparam int unsigned NCH     = (COUNT_BITS + 31) / 32;
  localparam int unsigned MAGP_W  = NCH * 32;
  localparam int unsigned PROD_W  = (COUNT_BITS + 32 > 64) ? 64 : COUNT_BITS + 32;
  localparam int unsigned DIV_CYC = (PROD_W + 7) / 8;
  localparam int unsigned DIVP_W  = DIV_CYC * 8;
  localparam int unsigned CNT_W   = $clog2(DIV_CYC + 1);
  localparam int unsigned VW      = qdv_pkg::VEL_W;

  qdv_pkg::md_state_e state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              done_q, done_d;
  logic              neg_q;
  logic [MAGP_W-1:0] mag_q;
  logic [31:0]       scale_q;
  logic [SPAN_W-1:0] span_q;
  logic [PROD_W-1:0] acc_q;
  logic [DIVP_W-1:0] quo_q;
  logic [SPAN_W-1:0] rem_q;
  logic [VW-1:0]     vel_q;

  logic [63:0]       pp;
  logic [PROD_W-1:0] acc_d;
  logic [DIVP_W-1:0] quo_d;
  logic [SPAN_W-1:0] rem_d;
  logic [VW-1:0]     quo_low;

  // top chunk first, so the accumulator shifts up by one chunk each cycle
  always_comb begin
    pp    = 64'(mag_q[MAGP_W-1 -: 32]) * 64'(scale_q);
    acc_d = (acc_q << 32) + PROD_W'(pp);
  end

  // restoring division, eight dependent steps on a narrow remainder
  always_comb begin
    logic [SPAN_W:0]   r;
    logic [DIVP_W-1:0] q;
    r = {1'b0, rem_q};
    q = quo_q;
    for (int i = 0; i < 8; i++) begin
      r = {r[SPAN_W-1:0], q[DIVP_W-1]};
      q = q << 1;
      if (r >= {1'b0, span_q}) begin
        r    = r - {1'b0, span_q};
        q[0] = 1'b1;
      end
    end
    quo_d   = q;
    rem_d   = r[SPAN_W-1:0];
    quo_low = quo_d[VW-1:0];
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    case (state_q)
      qdv_pkg::MD_IDLE: begin
        if (start_i) begin
          state_d = qdv_pkg::MD_MUL;
          cnt_d   = CNT_W'(NCH - 1);
        end
      end
      qdv_pkg::MD_MUL: begin
        if (cnt_q == '0) begin
          state_d = qdv_pkg::MD_DIV;
          cnt_d   = CNT_W'(DIV_CYC - 1);
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      qdv_pkg::MD_DIV: begin
        if (cnt_q == '0) begin
          state_d = qdv_pkg::MD_IDLE;
          done_d  = 1'b1;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      default: begin
        state_d = qdv_pkg::MD_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= qdv_pkg::MD_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      qdv_pkg::MD_IDLE: begin
        if (start_i) begin
          neg_q   <= neg_i;
          mag_q   <= MAGP_W'(mag_i);
          scale_q <= scale_i;
          span_q  <= span_i;
          acc_q   <= '0;
        end
      end
      qdv_pkg::MD_MUL: begin
        acc_q <= acc_d;
        mag_q <= mag_q << 32;
        if (cnt_q == '0) begin
          quo_q <= DIVP_W'(acc_d);
          rem_q <= '0;
        end
      end
      qdv_pkg::MD_DIV: begin
        quo_q <= quo_d;
        rem_q <= rem_d;
        if (cnt_q == '0) begin
          vel_q <= neg_q ? (~quo_low + 1'b1) : quo_low;
        end
      end
      default: begin
        acc_q <= acc_q;
      end
    endcase
  end

  assign done_o = done_q;
  assign vel_o  = vel_q;

endmodule

`default_nettype wire

// ----- rtl/core/quadrature_decode_velocity_top.sv -----
// 4x quadrature decoder with finite-difference velocity estimate, top level
// path: the first sample goes from IDLE straight to OUT; later samples pass READ, then CALC
//   while the velocity unit multiplies and divides, then OUT, where the result is registered
// flow: one sample at a time, next accepted the cycle after the result is registered;
//   a result may wait while the next sample runs
// reset: async active low; counters, pointers, state, config reset; payload, history not cleared
`default_nettype none

module quadrature_decode_velocity_top #(
  parameter int unsigned WINDOW_MAX = 64,
  parameter int unsigned COUNT_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        a_level_i,
  input  wire logic        b_level_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic signed [31:0] position_count_o,
  output logic signed [47:0] velocity_rpm_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [0:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  localparam int unsigned PTR_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned SPAN_W = $clog2(WINDOW_MAX + 1);
  localparam int unsigned CMP_W  = (SPAN_W > 7) ? SPAN_W : 7;
  localparam int unsigned IDX_W  = SPAN_W + 1;
  localparam int unsigned VW     = qdv_pkg::VEL_W;

  qdv_pkg::ctl_state_e state_q;

  logic [6:0]            win_q;
  logic [31:0]           scale_q;
  logic [1:0]            prev_ab_q;
  logic                  first_seen_q;
  logic [COUNT_BITS-1:0] count_q;
  logic [PTR_W-1:0]      ptr_q;
  logic [SPAN_W-1:0]     samples_q;
  logic [SPAN_W-1:0]     span_q;
  logic [VW-1:0]         vel_q;
  logic                  out_valid_q;
  logic [31:0]           pos_out_q;
  logic [VW-1:0]         vel_out_q;

  logic                  in_fire;
  logic                  out_load;
  logic [1:0]            ab;
  qdv_pkg::step_e        step;
  logic [COUNT_BITS-1:0] count_next;
  logic [CMP_W-1:0]      win_c;
  logic [CMP_W-1:0]      span_full;
  logic [SPAN_W-1:0]     span_c;
  logic [IDX_W-1:0]      idx_full;
  logic [PTR_W-1:0]      rd_idx;
  logic                  mem_re;
  logic                  mem_we;
  logic [COUNT_BITS-1:0] hist_rdata;
  logic [COUNT_BITS-1:0] delta;
  logic                  delta_neg;
  logic [COUNT_BITS-1:0] delta_mag;
  logic                  md_start;
  logic                  md_done;
  logic [VW-1:0]         md_vel;

  assign in_ready_o  = (state_q == qdv_pkg::S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_load    = (state_q == qdv_pkg::S_OUT) && (!out_valid_q || out_ready_i);
  assign ab          = {a_level_i, b_level_i};

  always_comb begin
    step = qdv_pkg::qdv_step(prev_ab_q, ab);
    case (step)
      qdv_pkg::STEP_UP:   count_next = count_q + 1'b1;
      qdv_pkg::STEP_DOWN: count_next = count_q - 1'b1;
      default:            count_next = count_q;
    endcase
  end

  // span: window clamped to 1..WINDOW_MAX, then limited by the samples held
  always_comb begin
    win_c = CMP_W'(win_q);
    if (win_c == '0) begin
      win_c = CMP_W'(1);
    end
    if (win_c > CMP_W'(WINDOW_MAX)) begin
      win_c = CMP_W'(WINDOW_MAX);
    end
    span_full = (win_c < CMP_W'(samples_q)) ? win_c : CMP_W'(samples_q);
    span_c    = SPAN_W'(span_full);
    if (IDX_W'(ptr_q) >= IDX_W'(span_c)) begin
      idx_full = IDX_W'(ptr_q) - IDX_W'(span_c);
    end else begin
      idx_full = IDX_W'(ptr_q) + IDX_W'(WINDOW_MAX) - IDX_W'(span_c);
    end
    rd_idx = idx_full[PTR_W-1:0];
  end

  // the read of the old count is issued before this sample's count goes into the ring
  assign mem_re = in_fire && first_seen_q;
  assign mem_we = out_load;

  qdv_hist_mem #(
    .DEPTH  (WINDOW_MAX),
    .ADDR_W (PTR_W),
    .DATA_W (COUNT_BITS)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (ptr_q),
    .wdata_i (count_q),
    .re_i    (mem_re),
    .raddr_i (rd_idx),
    .rdata_o (hist_rdata)
  );

  assign delta     = count_q - hist_rdata;
  assign delta_neg = delta[COUNT_BITS-1];
  assign delta_mag = delta_neg ? (~delta + 1'b1) : delta;
  assign md_start  = (state_q == qdv_pkg::S_READ);

  qdv_muldiv #(
    .COUNT_BITS (COUNT_BITS),
    .SPAN_W     (SPAN_W)
  ) u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (md_start),
    .neg_i   (delta_neg),
    .mag_i   (delta_mag),
    .scale_i (scale_q),
    .span_i  (span_q),
    .done_o  (md_done),
    .vel_o   (md_vel)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= qdv_pkg::WINDOW_RESET;
      scale_q <= qdv_pkg::SCALE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        qdv_pkg::CFG_AVERAGE_WINDOW: win_q   <= cfg_data_i[6:0];
        qdv_pkg::CFG_VELOCITY_SCALE: scale_q <= cfg_data_i;
        default:                     win_q   <= win_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= qdv_pkg::S_IDLE;
      prev_ab_q    <= 2'b00;
      first_seen_q <= 1'b0;
      count_q      <= '0;
      ptr_q        <= '0;
      samples_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        qdv_pkg::S_IDLE: begin
          if (in_fire) begin
            prev_ab_q <= ab;
            if (!first_seen_q) begin
              first_seen_q <= 1'b1;
              count_q      <= '0;
              state_q      <= qdv_pkg::S_OUT;
            end else begin
              count_q <= count_next;
              state_q <= qdv_pkg::S_READ;
            end
          end
        end
        qdv_pkg::S_READ: begin
          state_q <= qdv_pkg::S_CALC;
        end
        qdv_pkg::S_CALC: begin
          if (md_done) begin
            state_q <= qdv_pkg::S_OUT;
          end
        end
        qdv_pkg::S_OUT: begin
          if (out_load) begin
            state_q <= qdv_pkg::S_IDLE;
            if (ptr_q == PTR_W'(WINDOW_MAX - 1)) begin
              ptr_q <= '0;
            end else begin
              ptr_q <= ptr_q + 1'b1;
            end
            if (samples_q < SPAN_W'(WINDOW_MAX)) begin
              samples_q <= samples_q + 1'b1;
            end
          end
        end
        default: begin
          state_q <= qdv_pkg::S_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      span_q <= span_c;
      if (!first_seen_q) begin
        vel_q <= '0;
      end
    end
    if (md_done) begin
      vel_q <= md_vel;
    end
    if (out_load) begin
      pos_out_q <= 32'(count_q);
      vel_out_q <= vel_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign position_count_o = pos_out_q;
  assign velocity_rpm_o   = vel_out_q;

  // one sample in flight: no new transaction right after one is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_fire |=> !in_ready_o)
    else $error("input taken while a sample is in flight");

  // the velocity unit finishes only while the controller waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni) md_done |-> state_q == qdv_pkg::S_CALC)
    else $error("velocity unit done outside of the wait state");

  // the sample count never passes the ring depth
  assert property (@(posedge clk_i) disable iff (!rst_ni) samples_q <= SPAN_W'(WINDOW_MAX))
    else $error("sample count beyond ring depth");

  // a history read and a history write never coincide for one sample
  assert property (@(posedge clk_i) disable iff (!rst_ni) mem_re |-> !mem_we)
    else $error("history read and write in the same cycle");

  // every result register load is followed by a pending output
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_load |=> out_valid_o)
    else $error("result loaded without output valid");

endmodule

`default_nettype wire

// ----- tb/sv/quadrature_decode_velocity_top_test.sv -----
// self-checking testbench for the quadrature decoder with velocity estimate
`timescale 1ns / 100ps

module quadrature_decode_velocity_top_test;

  localparam int unsigned HISTORY_DEPTH   = 64;
  localparam int unsigned PHASES          = 12;
  localparam int unsigned SAMPLES_PER_SET = 152;
  localparam int unsigned SETTLE_CYCLES   = 30;

  // walks every one of the 16 previous/current pairs, then a short run each way
  localparam logic [1:0] PROBE_CODES [0:22] = '{
    2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd3, 2'd3, 2'd0, 2'd2, 2'd0, 2'd3,
    2'd1, 2'd3, 2'd2, 2'd1, 2'd0, 2'd1, 2'd3, 2'd2, 2'd3, 2'd1, 2'd0
  };

  typedef enum int {
    RX_STEADY,
    RX_SCATTERED,
    RX_BURSTY
  } rx_mode_e;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic               a_level_i   = 1'b0;
  logic               b_level_i   = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [31:0] position_count_o;
  logic signed [47:0] velocity_rpm_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [0:0]         cfg_index_i = qdv_pkg::CFG_AVERAGE_WINDOW;
  logic [31:0]        cfg_data_i  = '0;

  quadrature_decode_velocity_top #(
    .WINDOW_MAX(HISTORY_DEPTH),
    .COUNT_BITS(32)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .a_level_i       (a_level_i),
    .b_level_i       (b_level_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .position_count_o(position_count_o),
    .velocity_rpm_o  (velocity_rpm_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  class quad_scoreboard;
    logic [6:0]  window_cfg;
    logic [31:0] scale_cfg;
    logic [1:0]  last_ab;
    bit          primed;
    logic [31:0] count;
    logic [31:0] history [HISTORY_DEPTH];
    int unsigned hist_ptr;
    int unsigned hist_fill;
    logic [31:0] pos_expected [$];
    logic [47:0] vel_expected [$];
    int unsigned errors;
    int unsigned results_seen;

    function new();
      window_cfg   = qdv_pkg::WINDOW_RESET;
      scale_cfg    = qdv_pkg::SCALE_RESET;
      last_ab      = '0;
      primed       = 1'b0;
      count        = '0;
      hist_ptr     = 0;
      hist_fill    = 0;
      errors       = 0;
      results_seen = 0;
    endfunction

    function void write_reg(logic [0:0] index, logic [31:0] data);
      if (index == qdv_pkg::CFG_AVERAGE_WINDOW) begin
        window_cfg = data[6:0];
      end else begin
        scale_cfg = data;
      end
    endfunction

    function int unsigned pending();
      return pos_expected.size();
    endfunction

    function void report(string msg);
      errors++;
      $display("%0t: %s", $time, msg);
    endfunction

    // advance the decoder by one accepted sample and queue what it must answer
    function void note_sample(logic a, logic b);
      logic [1:0]      ab;
      qdv_pkg::step_e  mv;
      int unsigned     span;
      int unsigned     slot;
      logic [31:0]     delta;
      logic [31:0]     mag;
      logic [63:0]     quot;
      logic [47:0]     vel;
      ab  = {a, b};
      vel = '0;
      mv  = qdv_pkg::STEP_NONE;
      if (!primed) begin
        primed = 1'b1;
        count  = '0;
      end else begin
        case ({last_ab, ab})
          4'b0001, 4'b0111, 4'b1110, 4'b1000: mv = qdv_pkg::STEP_UP;
          4'b0010, 4'b1011, 4'b1101, 4'b0100: mv = qdv_pkg::STEP_DOWN;
          default: mv = qdv_pkg::STEP_NONE;
        endcase
        if (mv == qdv_pkg::STEP_UP) begin
          count = count + 32'd1;
        end else if (mv == qdv_pkg::STEP_DOWN) begin
          count = count - 32'd1;
        end
        span = (window_cfg == 0) ? 1 : int'(window_cfg);
        if (span > HISTORY_DEPTH) span = HISTORY_DEPTH;
        // still filling: only differentiate over what has been stored
        if (hist_fill < span) span = hist_fill;
        if (span > 0) begin
          slot  = (hist_ptr + HISTORY_DEPTH - span) % HISTORY_DEPTH;
          delta = count - history[slot];
          mag   = delta[31] ? -delta : delta;
          quot  = (64'(mag) * 64'(scale_cfg)) / 64'(span);
          vel   = delta[31] ? 48'(-quot) : quot[47:0];
        end
      end
      last_ab           = ab;
      history[hist_ptr] = count;
      hist_ptr          = (hist_ptr + 1) % HISTORY_DEPTH;
      if (hist_fill < HISTORY_DEPTH) hist_fill++;
      pos_expected.push_back(count);
      vel_expected.push_back(vel);
    endfunction

    function void check_result(logic [31:0] pos, logic [47:0] vel);
      logic [31:0] pos_exp;
      logic [47:0] vel_exp;
      results_seen++;
      if (pos_expected.size() == 0) begin
        report($sformatf("result with nothing expected: position %0d, velocity %0d",
                         $signed(pos), $signed(vel)));
        return;
      end
      pos_exp = pos_expected.pop_front();
      vel_exp = vel_expected.pop_front();
      if (pos !== pos_exp) begin
        report($sformatf("position_count mismatch: expected %0d, actual %0d",
                         $signed(pos_exp), $signed(pos)));
      end
      if (vel !== vel_exp) begin
        report($sformatf("velocity_rpm mismatch: expected %0d, actual %0d",
                         $signed(vel_exp), $signed(vel)));
      end
    endfunction
  endclass

  quad_scoreboard sb;

  rx_mode_e    rx_mode      = RX_STEADY;
  int unsigned hold_request = 0;
  int unsigned hold_left    = 0;
  int unsigned stall_run    = 0;
  int unsigned samples_sent = 0;

  logic [1:0]  motion_ab  = 2'd0;
  bit          motion_fwd = 1'b1;
  int unsigned run_left   = 0;

  logic [31:0] window_data [PHASES];
  logic [31:0] scale_data  [PHASES];

  // result side: check each transaction, then choose next cycle's ready
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result(position_count_o, velocity_rpm_o);
    end
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else if (hold_request > 0) begin
      out_ready_i  <= 1'b0;
      hold_left    = hold_request - 1;
      hold_request = 0;
    end else begin
      case (rx_mode)
        RX_STEADY: begin
          out_ready_i <= 1'b1;
        end
        RX_SCATTERED: begin
          out_ready_i <= ($urandom_range(0, 3) != 0);
        end
        default: begin
          if (stall_run > 0) begin
            out_ready_i <= 1'b0;
            stall_run--;
          end else if ($urandom_range(0, 7) == 0) begin
            out_ready_i <= 1'b0;
            stall_run = $urandom_range(0, 11);
          end else begin
            out_ready_i <= 1'b1;
          end
        end
      endcase
    end
  end

  // mostly clean motion in runs, with holds, double jumps and noise mixed in
  function automatic logic [1:0] next_motion_code();
    int unsigned r;
    if (run_left == 0) begin
      motion_fwd = $urandom_range(0, 1);
      run_left   = $urandom_range(1, 90);
    end
    run_left--;
    r = $urandom_range(0, 99);
    if (r < 4) begin
      motion_ab = 2'($urandom_range(0, 3));
    end else if (r < 8) begin
      motion_ab = motion_ab ^ 2'b11;
    end else if (r >= 15) begin
      case (motion_ab)
        2'd0: motion_ab = motion_fwd ? 2'd1 : 2'd2;
        2'd1: motion_ab = motion_fwd ? 2'd3 : 2'd0;
        2'd3: motion_ab = motion_fwd ? 2'd2 : 2'd1;
        default: motion_ab = motion_fwd ? 2'd0 : 2'd3;
      endcase
    end
    return motion_ab;
  endfunction

  task automatic send_sample(logic [1:0] code);
    a_level_i  <= code[1];
    b_level_i  <= code[0];
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_sample(code[1], code[0]);
    samples_sent++;
  endtask

  task automatic write_cfg(logic [0:0] index, logic [31:0] data);
    cfg_index_i <= index;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(index, data);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int unsigned phase;
    int unsigned burst_left;
    sb = new();
    window_data = '{32'd64, 32'd0, 32'd127, 32'hFFFF_FF85, 32'd1, 32'd63, 32'd2, 32'd65,
                    32'd0, 32'd0, 32'd0, 32'd0};
    scale_data  = '{32'h0001_0000, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'h8000_0000,
                    32'h0003_C000, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0};
    for (int i = 6; i < PHASES; i++) begin
      scale_data[i] = $urandom;
      if (i >= 8) window_data[i] = $urandom;
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed sweep under the reset register values
    for (int i = 0; i < 23; i++) begin
      send_sample(PROBE_CODES[i]);
    end
    motion_ab = PROBE_CODES[22];
    drain_results();

    for (phase = 0; phase < PHASES; phase++) begin
      write_cfg(qdv_pkg::CFG_AVERAGE_WINDOW, window_data[phase]);
      write_cfg(qdv_pkg::CFG_VELOCITY_SCALE, scale_data[phase]);
      cfg_valid_i <= 1'b0;
      @(negedge clk_i);
      rx_mode = rx_mode_e'(phase % 3);
      // long result-side hold while samples keep coming, to back up the input
      if (phase == 2) hold_request = 300;
      if (phase == 6) hold_request = 200;
      @(posedge clk_i);
      burst_left = $urandom_range(1, 24);
      for (int k = 0; k < SAMPLES_PER_SET; k++) begin
        if ((phase % 4 != 2) && burst_left == 0) begin
          in_valid_i <= 1'b0;
          repeat ($urandom_range(1, 18)) @(posedge clk_i);
          burst_left = $urandom_range(1, 24);
        end
        send_sample(next_motion_code());
        if (burst_left != 0) burst_left--;
      end
      drain_results();
    end

    $display("run covered %0d samples over %0d register settings, %0d results checked",
             samples_sent, PHASES + 1, sb.results_seen);
    $display("windows 0..127 with warm-up, scales 0 to all ones, with stalls on both sides");
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
